@@ hdl/wfos_pkg.sv @@
// Shared types, constants and helper functions for the waypoint follower.
// No dependencies; every other file of the block imports this package.
package wfos_pkg;

	localparam int WFOS_MAX_WAYPOINTS = 16;
	localparam int WFOS_CORDIC_STEPS  = 14;

	localparam int CORDIC_W = 40;        // CORDIC x/y datapath width

	localparam logic [15:0] SCAN_SEED    = 16'd10240;
	localparam logic [15:0] ANGLE_TOL    = 16'd1565;
	localparam logic [11:0] TURN_RATE    = 12'd410;
	localparam logic [6:0]  CRUISE_SPEED = 7'd123;
	localparam logic [6:0]  MIN_SPEED    = 7'd37;
	localparam logic [34:0] REACH_SQ     = 35'd65536;
	localparam logic [17:0] PI_Q16       = 18'd205887;
	localparam logic [11:0] RECIP_24     = 12'd2731;   // 65536/24, rounded up

	// input item kinds
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_ODOM  = 3'd1;
	localparam logic [2:0] KIND_RAY   = 3'd2;
	localparam logic [2:0] KIND_LOAD  = 3'd3;
	localparam logic [2:0] KIND_START = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_STOP  = 3'd0;
	localparam logic [2:0] CFG_SLOW  = 3'd1;
	localparam logic [2:0] CFG_FLOOR = 3'd2;
	localparam logic [2:0] CFG_CEIL  = 3'd3;
	localparam logic [2:0] CFG_RAYS  = 3'd4;

	typedef enum logic [1:0] {
		M_IDLE = 2'd0,
		M_ROT  = 2'd1,
		M_FWD  = 2'd2,
		M_WAIT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_ODOM,
		OP_RAY,
		OP_LOAD,
		OP_START
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_DXY,
		S_SQX,
		S_SQY,
		S_CINIT,
		S_CORD,
		S_DIFF,
		S_TURN,
		S_ANG,
		S_DIV
	} bstate_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] heading;
		logic [9:0]         ray_index;
		logic [15:0]        ray_range;
		logic               ray_finite;
		logic               last_ray;
	} req_t;

	typedef struct packed {
		logic [6:0]         fwd_cmd;
		logic signed [11:0] turn_cmd;
		logic [1:0]         mode;
		logic               route_done;
	} res_t;

	typedef struct packed {
		op_t  op;
		req_t item;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} fb_t;

	typedef struct packed {
		logic        en;
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	function automatic op_t classify(input logic [2:0] kind);
		op_t op;
		unique case (kind)
			KIND_TICK:  op = OP_TICK;
			KIND_ODOM:  op = OP_ODOM;
			KIND_RAY:   op = OP_RAY;
			KIND_LOAD:  op = OP_LOAD;
			KIND_START: op = OP_START;
			default:    op = OP_NONE;
		endcase
		return op;
	endfunction

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335086;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/wfos_front.sv @@
// Front end: accepts items, classifies them by kind and queues them.
// Depends on wfos_pkg.
module wfos_front
	import wfos_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  req_t   request,
	output fb_t    fb,
	input  logic   take
);

	entry_t     q_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	op_t        op;
	logic       wr, rd;

	assign op   = classify(request.kind);
	assign full = (cnt_q == 2'd2);
	// unknown kinds are accepted and dropped here
	assign wr   = push && !full && (op != OP_NONE);
	assign rd   = take && (cnt_q != 2'd0);

	assign fb.valid = (cnt_q != 2'd0);
	assign fb.entry = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wr_ptr_q] <= '{op: op, item: request};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= ~wr_ptr_q;
			if (rd) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

@@ hdl/wfos_back.sv @@
// Back end: configuration, robot and scan state, waypoint memory, the control
// sequencer with iterative CORDIC and divider, and the result queue.
// Depends on wfos_pkg.
module wfos_back
	import wfos_pkg::*;
#(
	parameter int MAX_WAYPOINTS = WFOS_MAX_WAYPOINTS,
	parameter int CORDIC_STEPS  = WFOS_CORDIC_STEPS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  fb_t     fb,
	output logic    take,
	output logic    empty,
	input  logic    pop,
	output res_t    result
);

	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int SW = $clog2(CORDIC_STEPS);

	// configuration
	logic [15:0] stop_q, slow_q, floor_q, ceil_q;
	logic [9:0]  rays_q;

	// control state
	bstate_t        st_q, st_d;
	mode_t          mode_q;
	logic [CW-1:0]  count_q, cursor_q;
	logic signed [15:0] rx_q, ry_q;
	logic [15:0]    yaw_q;
	logic [15:0]    smin_q, od_q;
	logic           blocked_q;

	logic [31:0]    store [MAX_WAYPOINTS];
	logic [31:0]    wp_q;

	// datapath
	logic signed [16:0] dx_q, dy_q;
	logic signed [CORDIC_W-1:0] cx_q, cy_q;
	logic [31:0]    cz_q;
	logic [SW-1:0]  step_q;
	logic           zero_q;
	logic signed [15:0] diff_q;
	logic [34:0]    sq_q;
	logic signed [11:0] ang_q;
	logic [22:0]    rem_q;
	logic [15:0]    den_q;
	logic [6:0]     quo_q;
	logic [2:0]     bit_q;

	// result queue
	res_t       oq_q [2];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;
	logic       opush, opop;
	res_t       odata;

	entry_t e;
	assign e = fb.entry;

	// ray cone
	logic [21:0] half_prod;
	logic [9:0]  half, idx;
	logic        in_cone, ray_ok;
	logic [15:0] new_min;
	assign half_prod = 22'(rays_q) * 22'(RECIP_24);
	assign half      = half_prod[21:12] >> 4;
	assign idx       = e.item.ray_index;
	assign in_cone   = (idx <= half) || ((idx >= rays_q - half) && (idx < rays_q));
	assign ray_ok    = e.item.ray_finite && (e.item.ray_range > floor_q) &&
	                   (e.item.ray_range < ceil_q) && in_cone && (e.item.ray_range < smin_q);
	assign new_min   = ray_ok ? e.item.ray_range : smin_q;

	// CORDIC step
	logic signed [CORDIC_W-1:0] xs, ys, cx0, cy0;
	logic [31:0] tab;
	assign xs  = cx_q >>> step_q;
	assign ys  = cy_q >>> step_q;
	assign tab = atan_entry(5'(step_q));
	assign cx0 = {{3{dx_q[16]}}, dx_q, 20'd0};
	assign cy0 = {{3{dy_q[16]}}, dy_q, 20'd0};

	// angle difference
	logic [31:0] zr;
	logic [15:0] tgt;
	logic signed [15:0] diff_c;
	logic        in_tol;
	assign zr     = cz_q + 32'd32768;
	assign tgt    = zero_q ? 16'd0 : zr[31:16];
	assign diff_c = signed'(tgt - yaw_q);
	assign in_tol = (diff_q > -signed'(ANGLE_TOL)) && (diff_q < signed'(ANGLE_TOL));

	// proportional turn rate
	logic [15:0] mag;
	logic [33:0] aprod;
	logic [11:0] amag;
	logic signed [11:0] ang_c;
	assign mag   = diff_q[15] ? 16'(-diff_q) : diff_q;
	assign aprod = 34'(mag) * 34'(PI_Q16) + 34'd2097152;
	assign amag  = aprod[33:22];
	assign ang_c = diff_q[15] ? -signed'(amag) : signed'(amag);

	// squared distance, from 16-bit magnitudes
	logic [15:0] adx, ady;
	logic [34:0] dy2, d2;
	assign adx = 16'(dx_q[16] ? -dx_q : dx_q);
	assign ady = 16'(dy_q[16] ? -dy_q : dy_q);
	assign dy2 = 35'(32'(ady) * 32'(ady));
	assign d2  = sq_q + dy2;

	// slowdown
	logic slow_zone, degen;
	logic [22:0] num;
	logic [22:0] dsh;
	logic        ge;
	logic [6:0]  qn;
	assign slow_zone = od_q < slow_q;
	assign degen     = (slow_q <= stop_q) || (od_q <= stop_q);
	assign num       = 23'(od_q - stop_q) * 23'(CRUISE_SPEED);
	assign dsh       = 23'(den_q) << bit_q;
	assign ge        = rem_q >= dsh;
	assign qn        = quo_q | (ge ? 7'(1) << bit_q : 7'd0);

	logic cur_last;
	assign cur_last = (cursor_q + CW'(1)) >= count_q;

	// sequencer
	always_comb begin
		st_d  = st_q;
		take  = 1'b0;
		opush = 1'b0;
		odata = '0;
		unique case (st_q)
			S_IDLE: begin
				take = fb.valid && (ocnt_q != 2'd2);
				if (take && e.op == OP_TICK) begin
					if (mode_q == M_IDLE) begin
						opush = 1'b1;
						odata.mode = M_IDLE;
					end else if ((mode_q == M_FWD || mode_q == M_WAIT) && blocked_q) begin
						opush = 1'b1;
						odata.mode = M_WAIT;
					end else begin
						st_d = S_RD;
					end
				end
			end
			S_RD:  st_d = S_DXY;
			S_DXY: st_d = (mode_q == M_ROT) ? S_CINIT : S_SQX;
			S_SQX: st_d = S_SQY;
			S_SQY: begin
				if (d2 < REACH_SQ) begin
					opush = 1'b1;
					st_d  = S_IDLE;
					if (cur_last) begin
						odata.mode = M_IDLE;
						odata.route_done = 1'b1;
					end else begin
						odata.mode = M_ROT;
					end
				end else begin
					st_d = S_CINIT;
				end
			end
			S_CINIT: st_d = S_CORD;
			S_CORD:  if (step_q == SW'(CORDIC_STEPS - 1)) st_d = S_DIFF;
			S_DIFF:  st_d = S_TURN;
			S_TURN: begin
				if (mode_q == M_ROT) begin
					opush = 1'b1;
					st_d  = S_IDLE;
					if (in_tol) begin
						odata.mode = M_FWD;
					end else begin
						odata.mode = M_ROT;
						odata.turn_cmd = diff_q[15] ? -signed'(TURN_RATE)
						                            : signed'(TURN_RATE);
					end
				end else begin
					st_d = S_ANG;
				end
			end
			S_ANG: begin
				if (slow_zone && !degen) begin
					st_d = S_DIV;
				end else begin
					opush = 1'b1;
					st_d  = S_IDLE;
					odata.mode = M_FWD;
					odata.turn_cmd = ang_c;
					odata.fwd_cmd = slow_zone ? MIN_SPEED : CRUISE_SPEED;
				end
			end
			S_DIV: begin
				if (bit_q == 3'd0) begin
					opush = 1'b1;
					st_d  = S_IDLE;
					odata.mode = M_FWD;
					odata.turn_cmd = ang_q;
					odata.fwd_cmd = (qn < MIN_SPEED) ? MIN_SPEED : qn;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else         st_q <= st_d;
	end

	// waypoint memory
	always_ff @(posedge clk) begin
		if (take && e.op == OP_LOAD && mode_q == M_IDLE && count_q < CW'(MAX_WAYPOINTS)) begin
			store[count_q[AW-1:0]] <= {e.item.coord_x, e.item.coord_y};
		end
		if (st_q == S_RD) begin
			wp_q <= (cursor_q < count_q && cursor_q < CW'(MAX_WAYPOINTS))
			        ? store[cursor_q[AW-1:0]] : 32'd0;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q    <= 16'd154;
			slow_q    <= 16'd205;
			floor_q   <= 16'd0;
			ceil_q    <= 16'hFFFF;
			rays_q    <= 10'd360;
			mode_q    <= M_IDLE;
			count_q   <= '0;
			cursor_q  <= '0;
			rx_q      <= '0;
			ry_q      <= '0;
			yaw_q     <= '0;
			smin_q    <= SCAN_SEED;
			od_q      <= SCAN_SEED;
			blocked_q <= 1'b0;
		end else begin
			if (cfg.en) begin
				unique case (cfg.index)
					CFG_STOP:  stop_q  <= cfg.data;
					CFG_SLOW:  slow_q  <= cfg.data;
					CFG_FLOOR: floor_q <= cfg.data;
					CFG_CEIL:  ceil_q  <= cfg.data;
					CFG_RAYS:  rays_q  <= cfg.data[9:0];
					default: ;
				endcase
			end
			if (take) begin
				unique case (e.op)
					OP_ODOM: begin
						rx_q  <= e.item.coord_x;
						ry_q  <= e.item.coord_y;
						yaw_q <= e.item.heading;
					end
					OP_RAY: begin
						if (e.item.last_ray) begin
							od_q      <= new_min;
							blocked_q <= new_min < stop_q;
							smin_q    <= SCAN_SEED;
						end else begin
							smin_q <= new_min;
						end
					end
					OP_LOAD: begin
						if (mode_q == M_IDLE && count_q < CW'(MAX_WAYPOINTS))
							count_q <= count_q + CW'(1);
					end
					OP_START: begin
						if (mode_q == M_IDLE && count_q != '0) begin
							cursor_q <= '0;
							mode_q   <= M_ROT;
						end
					end
					OP_TICK: begin
						if (mode_q == M_FWD && blocked_q) mode_q <= M_WAIT;
						else if (mode_q == M_WAIT && !blocked_q) mode_q <= M_FWD;
					end
					default: ;
				endcase
			end
			if (st_q == S_SQY && d2 < REACH_SQ) begin
				cursor_q <= cursor_q + CW'(1);
				if (cur_last) begin
					mode_q  <= M_IDLE;
					count_q <= '0;
				end else begin
					mode_q <= M_ROT;
				end
			end
			if (st_q == S_TURN && mode_q == M_ROT && in_tol) mode_q <= M_FWD;
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_DXY: begin
				dx_q <= 17'(signed'(wp_q[31:16])) - 17'(rx_q);
				dy_q <= 17'(signed'(wp_q[15:0])) - 17'(ry_q);
			end
			S_SQX: sq_q <= 35'(32'(adx) * 32'(adx));
			S_CINIT: begin
				zero_q <= (dx_q == '0) && (dy_q == '0);
				step_q <= '0;
				if (dx_q[16]) begin
					cx_q <= -cx0;
					cy_q <= -cy0;
					cz_q <= 32'h8000_0000;
				end else begin
					cx_q <= cx0;
					cy_q <= cy0;
					cz_q <= 32'd0;
				end
			end
			S_CORD: begin
				step_q <= step_q + SW'(1);
				if (!cy_q[CORDIC_W-1]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + tab;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - tab;
				end
			end
			S_DIFF: diff_q <= diff_c;
			S_ANG: begin
				ang_q <= ang_c;
				rem_q <= num;
				den_q <= slow_q - stop_q;
				quo_q <= '0;
				bit_q <= 3'd6;
			end
			S_DIV: begin
				if (ge) rem_q <= rem_q - dsh;
				quo_q <= qn;
				bit_q <= bit_q - 3'd1;
			end
			default: ;
		endcase
	end

	// result queue
	assign empty  = (ocnt_q == 2'd0);
	assign opop   = pop && !empty;
	assign result = oq_q[ord_q];

	always_ff @(posedge clk) begin
		if (opush) oq_q[owr_q] <= odata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) owr_q <= ~owr_q;
			if (opop)  ord_q <= ~ord_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
		end
	end

endmodule

@@ hdl/waypoint_follower_with_obstacle_stop_top.sv @@
// Top level of the waypoint follower with obstacle stop.
// Depends on wfos_pkg, wfos_front and wfos_back.
//
// Waypoint-following drive controller. Distances are in 1/1024 m, angles are
// 16-bit binary angles (32768 = pi). Request items load waypoints, start the
// route, update odometry, carry one lidar ray, or tick the control loop; only
// a tick produces a result item. The front end takes items into a two-entry
// queue (kinds 5..7 are accepted and dropped); the back end runs them one at
// a time. Odometry, ray, load and start items are applied as the back end
// takes them. An idle or blocked tick pushes its result when it is taken;
// else the waypoint is read and, outside rotation, checked for arrival; if
// not reached, the iterative CORDIC atan2 runs, one step per cycle, then
// the turn and any slowdown division. Results wait in a two-entry queue,
// and the back end starts a new item only while that queue has room.
// Configuration writes (wr_en, wr_index, wr_data) take effect at the next
// edge and must be made while the block is idle.
module waypoint_follower_with_obstacle_stop_top
	import wfos_pkg::*;
#(
	parameter int MAX_WAYPOINTS = WFOS_MAX_WAYPOINTS,
	parameter int CORDIC_STEPS  = WFOS_CORDIC_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  req_t        request,
	output logic        empty,
	input  logic        pop,
	output res_t        result,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);

	fb_t     fb;
	logic    take;
	cfg_wr_t cfg;

	assign cfg = '{en: wr_en, index: wr_index, data: wr_data};

	wfos_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.fb      (fb),
		.take    (take)
	);

	wfos_back #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS),
		.CORDIC_STEPS  (CORDIC_STEPS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fb     (fb),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

@@ hdl/wfos_checker.sv @@
// Port-level checks on result items of the waypoint follower, and the bind.
// Depends on wfos_pkg and waypoint_follower_with_obstacle_stop_top.
module wfos_checker
	import wfos_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input res_t result
);

	// a finished route reports idle with zero speeds
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.route_done) |->
		(result.mode == M_IDLE && result.fwd_cmd == 7'd0 &&
		 result.turn_cmd == 12'sd0))
		else $error("route_done with motion or non-idle mode");

	// only forward results move the robot forward
	a_lin: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mode != M_FWD) |-> (result.fwd_cmd == 7'd0))
		else $error("forward speed outside forward mode");

	// forward speed stays within the commanded band
	a_band: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mode == M_FWD && result.fwd_cmd != 7'd0) |->
		(result.fwd_cmd >= MIN_SPEED && result.fwd_cmd <= CRUISE_SPEED))
		else $error("forward speed out of range");

	// waiting and idle results never turn
	a_still: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.mode == M_WAIT || result.mode == M_IDLE)) |->
		(result.turn_cmd == 12'sd0))
		else $error("turn command while stopped");

	// a waiting result not taken stays on the ports
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while not taken");

endmodule

bind waypoint_follower_with_obstacle_stop_top wfos_checker u_wfos_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
